/* src/spq_pkg.sv */
package spq_pkg;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 8;
    localparam int MEM_W  = 16;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [MEM_W-1:0]  mem;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_READ,
        S_ENQ_CMP,
        S_DEQ_READ,
        S_DEQ_DATA,
        S_DONE
    } state_t;

endpackage

/* src/spq_req_if.sv */
interface spq_req_if;
    import spq_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [ID_W-1:0]   process_id;
    logic [PRIO_W-1:0] process_priority;
    logic [MEM_W-1:0]  memory_size;

    modport source (
        output valid, operation, process_id, process_priority, memory_size,
        input  ready
    );
    modport sink (
        input  valid, operation, process_id, process_priority, memory_size,
        output ready
    );
endinterface

/* src/spq_rsp_if.sv */
interface spq_rsp_if;
    import spq_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ID_W-1:0]   out_id;
    logic [PRIO_W-1:0] out_priority;
    logic [MEM_W-1:0]  out_memory;
    logic              record_valid;

    modport source (
        output valid, status, out_id, out_priority, out_memory, record_valid,
        input  ready
    );
    modport sink (
        input  valid, status, out_id, out_priority, out_memory, record_valid,
        output ready
    );
endinterface

/* src/stable_priority_queue_core.sv */
// Bounded priority queue of process records (id, priority, memory size).
// The req channel carries one command per beat: enqueue a record or dequeue
// the front record. Every command produces exactly one beat on the rsp
// channel with a status, and for a successful dequeue the removed record.
// Higher priority leaves first; equal priorities leave in arrival order.
// Records sit in a single-port-style memory used as a ring behind a head
// pointer, so a dequeue is one read. An enqueue scans from the tail toward
// the front, moving each record of lower priority back by one slot, with a
// read step and then a compare-and-write step per moved record. The scan
// stops at a compare that keeps the stored record ahead, or when the new
// record reaches the front. A full or empty refusal goes straight from
// idle to the response step.
// Only one command is in work at a time; req.ready is high when idle.
// The response register is separate from the sequencer, so the next
// command is taken while a response still waits on a stalled receiver;
// the sequencer then holds its result until the response register frees.
// Reset clears the count, the head pointer and the response valid. The
// memory is not cleared: entries are only read after being written.
module stable_priority_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [REC_W-1:0] mem_array [QUEUE_DEPTH];

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     idx_reg, idx_next;
    rec_t              new_rec_reg, new_rec_next;
    rec_t              pend_rec_reg, pend_rec_next;
    status_t           pend_status_reg, pend_status_next;
    logic              pend_has_rec_reg, pend_has_rec_next;
    rec_t              rd_data_reg;

    logic              rsp_valid_reg, rsp_valid_next;
    status_t           rsp_status_reg, rsp_status_next;
    rec_t              rsp_rec_reg, rsp_rec_next;
    logic              rsp_has_rec_reg, rsp_has_rec_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    rec_t              wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    // Logical slot to physical address; the sum stays below twice the depth.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (AW+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (AW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.out_id       = rsp_has_rec_reg ? rsp_rec_reg.id   : '0;
    assign rsp.out_priority = rsp_has_rec_reg ? rsp_rec_reg.prio : '0;
    assign rsp.out_memory   = rsp_has_rec_reg ? rsp_rec_reg.mem  : '0;
    assign rsp.record_valid = rsp_has_rec_reg;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        head_next         = head_reg;
        idx_next          = idx_reg;
        new_rec_next      = new_rec_reg;
        pend_rec_next     = pend_rec_reg;
        pend_status_next  = pend_status_reg;
        pend_has_rec_next = pend_has_rec_reg;
        rsp_valid_next    = rsp_valid_reg;
        rsp_status_next   = rsp_status_reg;
        rsp_rec_next      = rsp_rec_reg;
        rsp_has_rec_next  = rsp_has_rec_reg;
        wr_en             = 1'b0;
        wr_addr           = '0;
        wr_data           = new_rec_reg;
        rd_en             = 1'b0;
        rd_addr           = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    new_rec_next.id   = req.process_id;
                    new_rec_next.prio = req.process_priority;
                    new_rec_next.mem  = req.memory_size;
                    pend_has_rec_next = 1'b0;
                    if (op_t'(req.operation) == OP_ENQUEUE)
                    begin
                        if (count_reg == CW'(QUEUE_DEPTH))
                        begin
                            pend_status_next = ST_FULL;
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            idx_next   = count_reg[AW-1:0];
                            state_next = S_ENQ_READ;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            pend_status_next = ST_EMPTY;
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            state_next = S_DEQ_READ;
                        end
                    end
                end
            end
            S_ENQ_READ:
            begin
                if (idx_reg == '0)
                begin
                    wr_en            = 1'b1;
                    wr_addr          = phys(head_reg, idx_reg);
                    wr_data          = new_rec_reg;
                    count_next       = count_reg + CW'(1);
                    pend_status_next = ST_DONE;
                    state_next       = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = phys(head_reg, idx_reg - AW'(1));
                    state_next = S_ENQ_CMP;
                end
            end
            S_ENQ_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, idx_reg);
                if (rd_data_reg.prio >= new_rec_reg.prio)
                begin
                    // The stored record stays ahead; the new one goes right behind it.
                    wr_data          = new_rec_reg;
                    count_next       = count_reg + CW'(1);
                    pend_status_next = ST_DONE;
                    state_next       = S_DONE;
                end
                else
                begin
                    wr_data    = rd_data_reg;
                    idx_next   = idx_reg - AW'(1);
                    state_next = S_ENQ_READ;
                end
            end
            S_DEQ_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                state_next = S_DEQ_DATA;
            end
            S_DEQ_DATA:
            begin
                pend_rec_next     = rd_data_reg;
                pend_has_rec_next = 1'b1;
                pend_status_next  = ST_DONE;
                head_next         = phys(head_reg, AW'(1));
                count_next        = count_reg - CW'(1);
                state_next        = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_status_next  = pend_status_reg;
                    rsp_rec_next     = pend_rec_reg;
                    rsp_has_rec_next = pend_has_rec_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg          <= idx_next;
        new_rec_reg      <= new_rec_next;
        pend_rec_reg     <= pend_rec_next;
        pend_status_reg  <= pend_status_next;
        pend_has_rec_reg <= pend_has_rec_next;
        rsp_status_reg   <= rsp_status_next;
        rsp_rec_reg      <= rsp_rec_next;
        rsp_has_rec_reg  <= rsp_has_rec_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("record count exceeds queue depth");

    a_record_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.record_valid |-> rsp.status == ST_DONE)
        else $error("record returned with a failure status");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != S_IDLE)
        else $error("sequencer stayed idle after an accepted beat");

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ENQ_CMP |-> $past(state_reg) == S_ENQ_READ)
        else $error("compare step without a preceding read");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("memory read and write in the same cycle");

endmodule

/* dv/spq_order_checker.sv */
module spq_order_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    spq_req_if   req,
    spq_rsp_if   rsp,
    output int   mismatch_count,
    output int   awaited_count
);
    import spq_pkg::*;

    typedef struct {
        status_t           status;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [MEM_W-1:0]  mem;
        logic              record_valid;
    } rsp_beat_t;

    rec_t      queued_records[$];
    rsp_beat_t awaited_responses[$];

    // Updates the shadow queue for one command and returns the response it causes.
    function automatic rsp_beat_t apply_command(op_t op, rec_t incoming);
        rsp_beat_t beat;
        int        slot;
        beat.status       = ST_DONE;
        beat.id           = '0;
        beat.prio         = '0;
        beat.mem          = '0;
        beat.record_valid = 1'b0;
        if (op == OP_ENQUEUE)
        begin
            if (queued_records.size() >= QUEUE_DEPTH)
            begin
                beat.status = ST_FULL;
            end
            else
            begin
                // The new record goes behind every record of greater or equal priority.
                slot = 0;
                while (slot < queued_records.size() && queued_records[slot].prio >= incoming.prio)
                    slot++;
                queued_records.insert(slot, incoming);
            end
        end
        else if (queued_records.size() == 0)
        begin
            beat.status = ST_EMPTY;
        end
        else
        begin
            beat.id           = queued_records[0].id;
            beat.prio         = queued_records[0].prio;
            beat.mem          = queued_records[0].mem;
            beat.record_valid = 1'b1;
            void'(queued_records.pop_front());
        end
        return beat;
    endfunction

    task automatic note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_beat_t expected;
        rec_t      incoming;
        if (!rst_n)
        begin
            queued_records.delete();
            awaited_responses.delete();
            mismatch_count = 0;
            awaited_count  = 0;
        end
        else
        begin
            // A response is never given at the edge its command is accepted, so the
            // response beat of this edge is checked before the command beat is applied.
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    note_mismatch($sformatf("response beat with none awaited: status %0d id %h",
                                            rsp.status, rsp.out_id));
                end
                else
                begin
                    expected = awaited_responses.pop_front();
                    if (rsp.status !== expected.status || rsp.out_id !== expected.id
                        || rsp.out_priority !== expected.prio || rsp.out_memory !== expected.mem
                        || rsp.record_valid !== expected.record_valid)
                    begin
                        note_mismatch($sformatf(
                            {"expected st %0d id %h pr %h mem %h rv %b, ",
                             "got st %0d id %h pr %h mem %h rv %b"},
                            expected.status, expected.id, expected.prio, expected.mem,
                            expected.record_valid, rsp.status, rsp.out_id, rsp.out_priority,
                            rsp.out_memory, rsp.record_valid));
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                incoming.id   = req.process_id;
                incoming.prio = req.process_priority;
                incoming.mem  = req.memory_size;
                awaited_responses.push_back(apply_command(op_t'(req.operation), incoming));
            end
            awaited_count = awaited_responses.size();
        end
    end

endmodule

/* dv/tb_stable_priority_queue_core.sv */
module tb_stable_priority_queue_core;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH     = 16;
    localparam int PHASES          = 11;
    localparam int ITEMS_PER_PHASE = 102;
    localparam int LONG_HOLD       = 200;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 2 * QUEUE_DEPTH + 8;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_BLOCKY
    } rx_mode_t;

    logic clk;
    logic rst_n;
    logic hold_request;
    int   mismatch_count;
    int   awaited_count;
    int   idle_cycles;
    int   enqueue_pct;
    int   prio_lo;
    int   prio_hi;
    int   gap_max;

    spq_req_if req();
    spq_rsp_if rsp();

    stable_priority_queue_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    spq_order_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .mismatch_count(mismatch_count),
        .awaited_count (awaited_count)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Offers one command from a falling edge, holds it until accepted, then
    // optionally idles for the given number of cycles.
    task automatic send_command(op_t op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                                logic [MEM_W-1:0] mem, int gap);
        req.valid            = 1'b1;
        req.operation        = op;
        req.process_id       = id;
        req.process_priority = prio;
        req.memory_size      = mem;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        int burst_left;
        int gap;
        rst_n                = 1'b0;
        hold_request         = 1'b0;
        req.valid            = 1'b0;
        req.operation        = OP_ENQUEUE;
        req.process_id       = '0;
        req.process_priority = '0;
        req.memory_size      = '0;
        burst_left           = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty dequeue, field extremes, ties at both ends of the
        // priority range, filling to the limit and one refused enqueue.
        send_command(OP_DEQUEUE, '0, '0, '0, 1);
        send_command(OP_ENQUEUE, 16'h0000, 8'h00, 16'h0000, 0);
        send_command(OP_ENQUEUE, 16'hFFFF, 8'hFF, 16'hFFFF, 2);
        send_command(OP_ENQUEUE, 16'h1234, 8'h80, 16'h0001, 0);
        send_command(OP_ENQUEUE, 16'h1235, 8'h80, 16'h0002, 1);
        send_command(OP_ENQUEUE, 16'h0001, 8'hFF, 16'h8000, 0);
        send_command(OP_ENQUEUE, 16'h0002, 8'h00, 16'h7FFF, 3);
        repeat (3) send_command(OP_DEQUEUE, '0, '0, '0, $urandom_range(0, 2));
        for (int k = 0; k < 13; k++)
            send_command(OP_ENQUEUE, ID_W'(16'hA000 + k), PRIO_W'(k * 37),
                         MEM_W'(16'h5A5A ^ k), $urandom_range(0, 3));
        send_command(OP_ENQUEUE, 16'hBEEF, 8'hFF, 16'hFFFF, 0);
        send_command(OP_DEQUEUE, '0, '0, '0, 1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    enqueue_pct = 60; prio_lo = 0;   prio_hi = 255; gap_max = 6;
                end
                1:
                begin
                    enqueue_pct = 75; prio_lo = 0;   prio_hi = 3;   gap_max = 40;
                end
                2:
                begin
                    enqueue_pct = 30; prio_lo = 250; prio_hi = 255; gap_max = 0;
                end
                3:
                begin
                    enqueue_pct = 80; prio_lo = 0;   prio_hi = 255; gap_max = 2;
                end
                4:
                begin
                    enqueue_pct = 50; prio_lo = 0;   prio_hi = 7;   gap_max = 12;
                end
                5:
                begin
                    enqueue_pct = 20; prio_lo = 0;   prio_hi = 255; gap_max = 3;
                end
                6:
                begin
                    enqueue_pct = 90; prio_lo = 100; prio_hi = 103; gap_max = 8;
                end
                7:
                begin
                    enqueue_pct = 50; prio_lo = 0;   prio_hi = 255; gap_max = 0;
                end
                8:
                begin
                    enqueue_pct = 65; prio_lo = 0;   prio_hi = 1;   gap_max = 5;
                end
                9:
                begin
                    enqueue_pct = 40; prio_lo = 0;   prio_hi = 255; gap_max = 20;
                end
                default:
                begin
                    enqueue_pct = 55; prio_lo = 0;   prio_hi = 15;  gap_max = 4;
                end
            endcase
            // The receiver takes a long hold-off while this phase keeps offering
            // commands, so the block backs up and stops taking new ones.
            if (phase == 3)
                hold_request = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
                end
                else
                begin
                    gap = 0;
                end
                burst_left--;
                send_command(($urandom_range(1, 100) <= enqueue_pct) ? OP_ENQUEUE : OP_DEQUEUE,
                             ID_W'($urandom), PRIO_W'($urandom_range(prio_lo, prio_hi)),
                             MEM_W'($urandom), gap);
            end
            if (phase == 4)
            begin
                req.valid = 1'b0;
                wait (awaited_count == 0);
                @(negedge clk);
            end
        end

        req.valid = 1'b0;
        wait (awaited_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: segments of random length, each with its own stall pattern.
    initial
    begin
        int       seg_len;
        int       ready_pct;
        int       period;
        bit       hold_served;
        rx_mode_t mode;
        rsp.ready   = 1'b0;
        hold_served = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            seg_len   = $urandom_range(10, 150);
            mode      = rx_mode_t'($urandom_range(0, 3));
            ready_pct = $urandom_range(20, 90);
            period    = $urandom_range(2, 5);
            for (int k = 0; k < seg_len; k++)
            begin
                @(negedge clk);
                if (hold_request && !hold_served)
                begin
                    hold_served = 1'b1;
                    rsp.ready   = 1'b0;
                    repeat (LONG_HOLD) @(negedge clk);
                end
                case (mode)
                    RX_OPEN:   rsp.ready = 1'b1;
                    RX_RANDOM: rsp.ready = ($urandom_range(1, 100) <= ready_pct);
                    RX_SPARSE: rsp.ready = (k % period) != 0;
                    default:   rsp.ready = (k % (2 * period)) < period;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

/* filelist.f */
src/spq_pkg.sv
src/spq_req_if.sv
src/spq_rsp_if.sv
src/stable_priority_queue_core.sv
dv/spq_order_checker.sv
dv/tb_stable_priority_queue_core.sv
